### rtl/psc_pkg.sv
`default_nettype none

package psc_pkg;

  localparam int CH_W      = 3;
  localparam int Q15_W     = 15;
  localparam int FRAC_W    = 8;
  localparam int AVG_W     = Q15_W + FRAC_W;
  localparam int SHIFT_W   = 3;
  localparam int PROD_W    = 2 * Q15_W;
  localparam int STEP_W    = 4;

  localparam int CHANNELS_DEF = 8;

  localparam logic [Q15_W-1:0]   Q15_MAX             = 15'h7fff;
  localparam logic [Q15_W-1:0]   FULL_SCALE_RST      = 15'd25000;
  localparam logic [Q15_W-1:0]   POPUP_DELTA_RST     = 15'd128;
  localparam logic [CH_W-1:0]    TAPER_CHANNEL_RST   = 3'd7;
  localparam logic [SHIFT_W-1:0] SMOOTHING_SHIFT_RST = 3'd2;

  typedef enum logic [1:0] {
    REG_FULL_SCALE      = 2'd0,
    REG_POPUP_DELTA     = 2'd1,
    REG_TAPER_CHANNEL   = 2'd2,
    REG_SMOOTHING_SHIFT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [Q15_W-1:0] sample;
    logic             read_error;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel_out;
    logic [Q15_W-1:0] level;
    logic             popup;
  } out_item_t;

  typedef struct packed {
    cfg_reg_e         index;
    logic [Q15_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

### rtl/psc_stream_if.sv
`default_nettype none

interface psc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/psc_ram.sv
`default_nettype none

module psc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/pot_smoothing_and_change_detect_top.sv
`default_nettype none

// Per-channel potentiometer smoother with change detection. Each beat on
// in_i with read_error clear and a channel below CHANNELS updates that
// channel's moving average (8 fraction bits), scales it to Q15 against
// full_scale, squares it on the taper channel and produces one beat on
// out_o; popup is set on a channel's first result or when the level has
// moved by more than popup_delta since the last announced one. Items with
// read_error set, or for an absent channel, are taken and dropped. Timing
// is set by the bit-serial divider and multiplier, one bit per cycle each.
// A kept item passes through the memory read, the average update, the
// divide and, on the taper channel, the multiply, then the compare and
// the output register; at or above full scale divide and multiply are
// skipped. in_i is ready again in the cycle the result turns valid on
// out_o, and the next item is taken while that result waits there. The
// configuration port is always ready and must only be written while idle.
module pot_smoothing_and_change_detect_top #(
  parameter int CHANNELS = psc_pkg::CHANNELS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  psc_stream_if.sink   in_i,
  psc_stream_if.source out_o,
  psc_stream_if.sink   cfg_i
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int Q15_W  = psc_pkg::Q15_W;
  localparam int AVG_W  = psc_pkg::AVG_W;
  localparam int PROD_W = psc_pkg::PROD_W;
  localparam int STEP_W = psc_pkg::STEP_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(Q15_W - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_AVG  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // configuration
  logic [Q15_W-1:0]                 full_scale_q;
  logic [Q15_W-1:0]                 popup_delta_q;
  logic [psc_pkg::CH_W-1:0]         taper_channel_q;
  logic [psc_pkg::SHIFT_W-1:0]      smoothing_shift_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q      <= psc_pkg::FULL_SCALE_RST;
      popup_delta_q     <= psc_pkg::POPUP_DELTA_RST;
      taper_channel_q   <= psc_pkg::TAPER_CHANNEL_RST;
      smoothing_shift_q <= psc_pkg::SMOOTHING_SHIFT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        psc_pkg::REG_FULL_SCALE:      full_scale_q      <= cfg_i.payload.data;
        psc_pkg::REG_POPUP_DELTA:     popup_delta_q     <= cfg_i.payload.data;
        psc_pkg::REG_TAPER_CHANNEL:
          taper_channel_q   <= cfg_i.payload.data[psc_pkg::CH_W-1:0];
        psc_pkg::REG_SMOOTHING_SHIFT:
          smoothing_shift_q <= cfg_i.payload.data[psc_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath state
  logic [2:0]               state_q, state_d;
  logic [STEP_W-1:0]        cnt_q, cnt_d;
  logic [psc_pkg::CH_W-1:0] ch_q, ch_d;
  logic [AW-1:0]            addr_q, addr_d;
  logic [Q15_W-1:0]         sample_q, sample_d;
  logic [Q15_W-1:0]         rem_q, rem_d;     // divider remainder
  logic [Q15_W-1:0]         shr_q, shr_d;     // dividend low bits / quotient / multiplier
  logic [PROD_W-1:0]        acc_q, acc_d;
  logic [Q15_W-1:0]         lvl_q, lvl_d;
  logic                     popup_q, popup_d;
  logic [CHANNELS-1:0]      avg_vld_q, avg_vld_d;
  logic [CHANNELS-1:0]      ann_vld_q, ann_vld_d;
  logic                     out_vld_q, out_vld_d;
  psc_pkg::out_item_t       out_q, out_d;

  logic [AVG_W-1:0] avg_rdata, avg_new;
  logic [Q15_W-1:0] ann_rdata;
  logic             avg_we, ann_we, mem_re;

  logic                    in_fire, in_keep;
  logic signed [AVG_W:0]   avg_diff, avg_step;
  logic [AVG_W-1:0]        target;
  logic [Q15_W-1:0]        smoothed;
  logic [PROD_W-1:0]       dividend;
  logic [Q15_W:0]          div_trial;
  logic                    div_bit;
  logic [Q15_W-1:0]        quotient;
  logic                    is_taper;
  logic [Q15_W-1:0]        lvl_diff;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_keep    = !in_i.payload.read_error && (32'(in_i.payload.channel) < CHANNELS);

  assign target   = {sample_q, {psc_pkg::FRAC_W{1'b0}}};
  assign avg_diff = $signed({1'b0, target}) - $signed({1'b0, avg_rdata});
  assign avg_step = avg_diff >>> smoothing_shift_q;
  always_comb begin
    if (avg_vld_q[addr_q]) begin
      avg_new = AVG_W'($signed({1'b0, avg_rdata}) + avg_step);
    end else begin
      avg_new = target;
    end
  end
  assign smoothed = avg_new[AVG_W-1:psc_pkg::FRAC_W];
  // smoothed * 32767 as a shift and subtract
  assign dividend = {smoothed, {Q15_W{1'b0}}} - PROD_W'(smoothed);

  assign div_trial = {rem_q, shr_q[Q15_W-1]};
  assign div_bit   = (div_trial >= {1'b0, full_scale_q});
  assign quotient  = {shr_q[Q15_W-2:0], div_bit};
  assign is_taper  = (ch_q == taper_channel_q);
  assign lvl_diff  = (lvl_q > ann_rdata) ? (lvl_q - ann_rdata) : (ann_rdata - lvl_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ch_d      = ch_q;
    addr_d    = addr_q;
    sample_d  = sample_q;
    rem_d     = rem_q;
    shr_d     = shr_q;
    acc_d     = acc_q;
    lvl_d     = lvl_q;
    popup_d   = popup_q;
    avg_vld_d = avg_vld_q;
    ann_vld_d = ann_vld_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    avg_we    = 1'b0;
    ann_we    = 1'b0;
    mem_re    = 1'b0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire && in_keep) begin
          ch_d     = in_i.payload.channel;
          addr_d   = AW'(in_i.payload.channel);
          sample_d = in_i.payload.sample;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_AVG;
      end
      S_AVG: begin
        avg_we            = 1'b1;
        avg_vld_d[addr_q] = 1'b1;
        cnt_d             = '0;
        acc_d             = '0;
        // at or above full scale the quotient saturates, so skip the divide
        if (smoothed >= full_scale_q) begin
          lvl_d   = psc_pkg::Q15_MAX;
          state_d = S_CMP;
        end else begin
          rem_d   = dividend[PROD_W-1:Q15_W];
          shr_d   = dividend[Q15_W-1:0];
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = div_bit ? Q15_W'(div_trial - {1'b0, full_scale_q})
                        : div_trial[Q15_W-1:0];
        shr_d = quotient;
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == LAST_STEP) begin
          // quotient here is always below full level
          lvl_d   = quotient;
          cnt_d   = '0;
          state_d = is_taper ? S_MUL : S_CMP;
        end
      end
      S_MUL: begin
        acc_d = {acc_q[PROD_W-2:0], 1'b0}
              + (shr_q[Q15_W-1] ? PROD_W'(lvl_q) : PROD_W'(0));
        shr_d = {shr_q[Q15_W-2:0], 1'b0};
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == LAST_STEP) begin
          lvl_d   = acc_d[PROD_W-1:Q15_W];
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        popup_d = !ann_vld_q[addr_q] || (lvl_diff > popup_delta_q);
        if (popup_d) begin
          ann_we            = 1'b1;
          ann_vld_d[addr_q] = 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d         = 1'b1;
          out_d.channel_out = ch_q;
          out_d.level       = lvl_q;
          out_d.popup       = popup_q;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      avg_vld_q <= '0;
      ann_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      avg_vld_q <= avg_vld_d;
      ann_vld_q <= ann_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    addr_q   <= addr_d;
    sample_q <= sample_d;
    rem_q    <= rem_d;
    shr_q    <= shr_d;
    acc_q    <= acc_d;
    lvl_q    <= lvl_d;
    popup_q  <= popup_d;
    out_q    <= out_d;
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  psc_ram #(
    .WIDTH (AVG_W),
    .DEPTH (CHANNELS)
  ) u_avg_ram (
    .clk_i   (clk_i),
    .we_i    (avg_we),
    .waddr_i (addr_q),
    .wdata_i (avg_new),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (avg_rdata)
  );

  psc_ram #(
    .WIDTH (Q15_W),
    .DEPTH (CHANNELS)
  ) u_ann_ram (
    .clk_i   (clk_i),
    .we_i    (ann_we),
    .waddr_i (addr_q),
    .wdata_i (lvl_q),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (ann_rdata)
  );

  // a kept item always starts a memory read next cycle
  a_keep_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_keep) |=> (state_q == S_READ))
    else $error("kept item did not start a read");

  // the serial units run their full count
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q != LAST_STEP) |=> (state_q == S_DIV))
    else $error("divide left early");

  a_mul_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && cnt_q != LAST_STEP) |=> (state_q == S_MUL))
    else $error("multiply left early");

  // a channel's first result always announces
  a_first_popup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && !ann_vld_q[addr_q]) |=> (popup_q && ann_vld_q[$past(addr_q)]))
    else $error("first result without popup");

endmodule

`default_nettype wire
